/* sv/fragment_frame_parser_defines.svh */
// Assertion macros shared by the fragment frame parser RTL.
// Depends on nothing; define NO_ASSERTIONS to compile the checks away.
`ifndef FRAGMENT_FRAME_PARSER_DEFINES_SVH
`define FRAGMENT_FRAME_PARSER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define FFP_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fragment frame parser check failed");
`define FFP_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fragment frame parser check failed");
`else
`define FFP_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define FFP_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* sv/ffp_pkg.sv */
// Package of the fragment frame parser: constants, payload and status types, helpers.
// Depends on nothing.
`default_nettype none
package ffp_pkg;

   localparam int HEADER_BYTES = 24;
   localparam int POS_W        = 17;
   localparam logic [POS_W-1:0] POS_MAX = '1;

   // Header field offsets
   localparam logic [POS_W-1:0] OFS_TYPE   = 17'd0;
   localparam logic [POS_W-1:0] OFS_CLASS  = 17'd1;
   localparam logic [POS_W-1:0] OFS_PAD    = 17'd2;
   localparam logic [POS_W-1:0] OFS_IDENT  = 17'd4;
   localparam logic [POS_W-1:0] OFS_TOTAL  = 17'd12;
   localparam logic [POS_W-1:0] OFS_INDEX  = 17'd14;
   localparam logic [POS_W-1:0] OFS_COUNT  = 17'd16;
   localparam logic [POS_W-1:0] OFS_BUDGET = 17'd18;
   localparam logic [POS_W-1:0] OFS_CRC    = 17'd20;
   localparam logic [POS_W-1:0] OFS_END    = POS_W'(HEADER_BYTES);

   localparam int CLASS_LIMIT = 9;
   localparam int CLASS_BASE  = 32;

   localparam int MUL_W     = 16;
   localparam int MUL_CNT_W = $clog2(MUL_W);

   localparam logic [7:0]  TYPE_CODE_RST = 8'd1;
   localparam logic [15:0] MAX_MSG_RST   = 16'd8192;
   localparam logic [3:0]  MAX_CLASS_RST = 4'd8;
   localparam logic [63:0] ID_LIMIT_RST  = '1;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 64;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TYPE_CODE = 2'd0,
      CSR_MAX_MSG   = 2'd1,
      CSR_MAX_CLASS = 2'd2,
      CSR_ID_LIMIT  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_frame;
   } req_type;

   typedef struct packed {
      logic        is_summary;
      logic [7:0]  payload_byte;
      logic        is_last;
      logic        status;
      logic [7:0]  msg_class;
      logic [63:0] msg_ident;
      logic [15:0] total_len;
      logic [15:0] frag_index;
      logic [15:0] frag_count;
      logic [15:0] data_budget;
      logic [31:0] msg_crc;
      logic [15:0] payload_len;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  type_code;
      logic [15:0] max_msg;
      logic [3:0]  max_class;
      logic [63:0] id_limit;
   } cfg_type;

   typedef struct packed {
      logic [POS_W-1:0] position;
      logic             format_ok;
      logic [7:0]       cls;
      logic [63:0]      ident;
      logic [15:0]      total;
      logic [15:0]      index;
      logic [15:0]      count;
      logic [15:0]      budget;
      logic [31:0]      crc;
   } hdr_type;

   typedef struct packed {
      logic done;
      logic malformed;
   } chk_status_type;

   function automatic logic [POS_W-1:0] data_len_f(logic [POS_W-1:0] pos);
      return (pos > OFS_END) ? (pos - OFS_END) : '0;
   endfunction

   function automatic logic [15:0] class_size_f(logic [7:0] cls);
      return (cls < 8'(CLASS_LIMIT)) ? (16'(CLASS_BASE) << cls[3:0]) : '0;
   endfunction

endpackage
`default_nettype wire

/* sv/fragment_frame_parser.sv */
// Top level of the fragment frame parser: channels, configuration registers, result register.
// Depends on ffp_pkg, ffp_hdr, ffp_chk and fragment_frame_parser_defines.svh.
//
// Usage:
//  - req_* carries one frame byte per request, end_of_frame set on the last byte.
//    The first 24 bytes are the header and give no result.
//  - Each later byte is forwarded as a payload result on rsp_* in the cycle after
//    its request is taken; header and payload bytes are taken one per cycle while
//    no frame end is being checked, payload bytes only while the result register is free.
//  - The end-of-frame request yields a summary result (is_last set) once the frame-end
//    check is done and the result register is free. The bit-serial multiplier that
//    checks the fragment count and the last fragment length runs within that check;
//    no request is taken until the summary sits in the result register.
//  - csr_* writes a configuration register; write only while idle.
//  - Reset (synchronous) loads the default configuration and returns to frame start.
//  - When rsp_ready is low the result stays in its register; header bytes keep
//    flowing, payload bytes wait until the register frees up.
`default_nettype none
`include "fragment_frame_parser_defines.svh"
module fragment_frame_parser (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire ffp_pkg::req_type                 req_data,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output ffp_pkg::rsp_type                      rsp_data,
   input  wire logic                             csr_write_en,
   input  wire logic [ffp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [ffp_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   ffp_pkg::cfg_type         cfg_ff, cfg_in;
   ffp_pkg::hdr_type         hdr;
   ffp_pkg::chk_status_type  chk_sts;
   ffp_pkg::rsp_type         rsp_data_ff, rsp_data_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     busy_ff, busy_in;
   logic                     start_ff;
   logic                     in_header;
   logic                     req_fire;
   logic                     pay_fire;
   logic                     eof_fire;
   logic                     out_free;
   logic                     sum_load;
   logic [ffp_pkg::POS_W-1:0] dlen;

   // Configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            ffp_pkg::CSR_TYPE_CODE: cfg_in.type_code = csr_wdata[7:0];
            ffp_pkg::CSR_MAX_MSG:   cfg_in.max_msg   = csr_wdata[15:0];
            ffp_pkg::CSR_MAX_CLASS: cfg_in.max_class = csr_wdata[3:0];
            ffp_pkg::CSR_ID_LIMIT:  cfg_in.id_limit  = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.type_code <= ffp_pkg::TYPE_CODE_RST;
         cfg_ff.max_msg   <= ffp_pkg::MAX_MSG_RST;
         cfg_ff.max_class <= ffp_pkg::MAX_CLASS_RST;
         cfg_ff.id_limit  <= ffp_pkg::ID_LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Request side: header bytes need no result slot, payload bytes do.
   // Hold everything while a frame end is being checked.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = !busy_ff && (in_header || out_free);
   assign req_fire  = req_valid && req_ready;
   assign pay_fire  = req_fire && !in_header;
   assign eof_fire  = req_fire && req_data.end_of_frame;

   // Summary moves into the result register once checked and the slot is free
   assign sum_load  = chk_sts.done && out_free;

   ffp_hdr u_hdr (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_fire),
      .in_byte   (req_data.in_byte),
      .clear     (sum_load),
      .type_code (cfg_ff.type_code),
      .hdr       (hdr),
      .in_header (in_header)
   );

   ffp_chk u_chk (
      .clock (clock),
      .reset (reset),
      .start (start_ff),
      .take  (sum_load),
      .hdr   (hdr),
      .cfg   (cfg_ff),
      .sts   (chk_sts)
   );

   assign dlen = ffp_pkg::data_len_f(hdr.position);

   always_comb begin
      busy_in = busy_ff;
      if (eof_fire) busy_in = 1'b1;
      else if (sum_load) busy_in = 1'b0;
   end

   // Result register: load payload or summary, drop on handshake, else hold
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (pay_fire) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in              = '0;
         rsp_data_in.payload_byte = req_data.in_byte;
      end else if (sum_load) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.is_summary   = 1'b1;
         rsp_data_in.payload_byte = '0;
         rsp_data_in.is_last      = 1'b1;
         rsp_data_in.status       = chk_sts.malformed;
         rsp_data_in.msg_class    = hdr.cls;
         rsp_data_in.msg_ident    = hdr.ident;
         rsp_data_in.total_len    = hdr.total;
         rsp_data_in.frag_index   = hdr.index;
         rsp_data_in.frag_count   = hdr.count;
         rsp_data_in.data_budget  = hdr.budget;
         rsp_data_in.msg_crc      = hdr.crc;
         // saturate the payload length at 16 bits
         rsp_data_in.payload_len  = dlen[ffp_pkg::POS_W-1] ? 16'hFFFF : dlen[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         busy_ff      <= 1'b0;
         start_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         busy_ff      <= busy_in;
         start_ff     <= eof_fire;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `FFP_ASSERT_IMP(a_start_in_frame_end, clock, reset, start_ff, busy_ff)
   `FFP_ASSERT_IMP(a_chk_done_in_frame_end, clock, reset, chk_sts.done, busy_ff)
   `FFP_ASSERT_NXT(a_frame_cleared, clock, reset, sum_load, (hdr.position == '0) && hdr.format_ok)

endmodule
`default_nettype wire

/* sv/ffp_hdr.sv */
// Header capture of the fragment frame parser: byte position and header shift registers.
// Depends on ffp_pkg.
`default_nettype none
module ffp_hdr (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           accept,
   input  wire logic [7:0]     in_byte,
   input  wire logic           clear,
   input  wire logic [7:0]     type_code,
   output ffp_pkg::hdr_type    hdr,
   output logic                in_header
);

   logic [ffp_pkg::POS_W-1:0] pos_ff, pos_in;
   logic                      fmt_ok_ff, fmt_ok_in;
   logic [7:0]                cls_ff, cls_in;
   logic [63:0]               ident_ff, ident_in;
   logic [15:0]               total_ff, total_in;
   logic [15:0]               index_ff, index_in;
   logic [15:0]               count_ff, count_in;
   logic [15:0]               budget_ff, budget_in;
   logic [31:0]               crc_ff, crc_in;

   always_comb begin
      pos_in    = pos_ff;
      fmt_ok_in = fmt_ok_ff;
      cls_in    = cls_ff;
      ident_in  = ident_ff;
      total_in  = total_ff;
      index_in  = index_ff;
      count_in  = count_ff;
      budget_in = budget_ff;
      crc_in    = crc_ff;
      if (clear) begin
         pos_in    = '0;
         fmt_ok_in = 1'b1;
         cls_in    = '0;
         ident_in  = '0;
         total_in  = '0;
         index_in  = '0;
         count_in  = '0;
         budget_in = '0;
         crc_in    = '0;
      end else if (accept) begin
         // check one header byte or shift it into its field
         case (pos_ff) inside
            ffp_pkg::OFS_TYPE: begin
               if (in_byte != type_code) fmt_ok_in = 1'b0;
            end
            ffp_pkg::OFS_CLASS: begin
               cls_in = in_byte;
            end
            [ffp_pkg::OFS_PAD : ffp_pkg::OFS_IDENT - 17'd1]: begin
               if (in_byte != 8'd0) fmt_ok_in = 1'b0;
            end
            [ffp_pkg::OFS_IDENT : ffp_pkg::OFS_TOTAL - 17'd1]: begin
               ident_in = {ident_ff[55:0], in_byte};
            end
            [ffp_pkg::OFS_TOTAL : ffp_pkg::OFS_INDEX - 17'd1]: begin
               total_in = {total_ff[7:0], in_byte};
            end
            [ffp_pkg::OFS_INDEX : ffp_pkg::OFS_COUNT - 17'd1]: begin
               index_in = {index_ff[7:0], in_byte};
            end
            [ffp_pkg::OFS_COUNT : ffp_pkg::OFS_BUDGET - 17'd1]: begin
               count_in = {count_ff[7:0], in_byte};
            end
            [ffp_pkg::OFS_BUDGET : ffp_pkg::OFS_CRC - 17'd1]: begin
               budget_in = {budget_ff[7:0], in_byte};
            end
            [ffp_pkg::OFS_CRC : ffp_pkg::OFS_END - 17'd1]: begin
               crc_in = {crc_ff[23:0], in_byte};
            end
            default: begin
            end
         endcase
         if (pos_ff != ffp_pkg::POS_MAX) pos_in = pos_ff + 17'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         fmt_ok_ff <= 1'b1;
         cls_ff    <= '0;
         ident_ff  <= '0;
         total_ff  <= '0;
         index_ff  <= '0;
         count_ff  <= '0;
         budget_ff <= '0;
         crc_ff    <= '0;
      end else begin
         pos_ff    <= pos_in;
         fmt_ok_ff <= fmt_ok_in;
         cls_ff    <= cls_in;
         ident_ff  <= ident_in;
         total_ff  <= total_in;
         index_ff  <= index_in;
         count_ff  <= count_in;
         budget_ff <= budget_in;
         crc_ff    <= crc_in;
      end
   end

   assign in_header = (pos_ff < ffp_pkg::OFS_END);

   always_comb begin
      hdr.position  = pos_ff;
      hdr.format_ok = fmt_ok_ff;
      hdr.cls       = cls_ff;
      hdr.ident     = ident_ff;
      hdr.total     = total_ff;
      hdr.index     = index_ff;
      hdr.count     = count_ff;
      hdr.budget    = budget_ff;
      hdr.crc       = crc_ff;
   end

endmodule
`default_nettype wire

/* sv/ffp_mul.sv */
// Bit-serial shift-add multiplier: two products sharing one multiplicand, one bit a cycle.
// Depends on ffp_pkg.
`default_nettype none
module ffp_mul (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [ffp_pkg::MUL_W-1:0] mcand,
   input  wire logic [ffp_pkg::MUL_W-1:0] mplier_a,
   input  wire logic [ffp_pkg::MUL_W-1:0] mplier_b,
   output logic                           done,
   output logic [2*ffp_pkg::MUL_W-1:0]    prod_a,
   output logic [2*ffp_pkg::MUL_W-1:0]    prod_b
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [ffp_pkg::MUL_CNT_W-1:0] cnt_ff, cnt_in;
   logic [2*ffp_pkg::MUL_W-1:0]   mcand_ff, mcand_in;
   logic [ffp_pkg::MUL_W-1:0]     a_ff, a_in;
   logic [ffp_pkg::MUL_W-1:0]     b_ff, b_in;
   logic [2*ffp_pkg::MUL_W-1:0]   acc_a_ff, acc_a_in;
   logic [2*ffp_pkg::MUL_W-1:0]   acc_b_ff, acc_b_in;
   logic                          last_step;

   assign last_step = (cnt_ff == ffp_pkg::MUL_CNT_W'(ffp_pkg::MUL_W - 1));

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      mcand_in = mcand_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      acc_a_in = acc_a_ff;
      acc_b_in = acc_b_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         mcand_in = {{ffp_pkg::MUL_W{1'b0}}, mcand};
         a_in     = mplier_a;
         b_in     = mplier_b;
         acc_a_in = '0;
         acc_b_in = '0;
      end else if (busy_ff) begin
         if (a_ff[0]) acc_a_in = acc_a_ff + mcand_ff;
         if (b_ff[0]) acc_b_in = acc_b_ff + mcand_ff;
         mcand_in = {mcand_ff[2*ffp_pkg::MUL_W-2:0], 1'b0};
         a_in     = {1'b0, a_ff[ffp_pkg::MUL_W-1:1]};
         b_in     = {1'b0, b_ff[ffp_pkg::MUL_W-1:1]};
         cnt_in   = cnt_ff + ffp_pkg::MUL_CNT_W'(1);
         if (last_step) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff <= mcand_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      acc_a_ff <= acc_a_in;
      acc_b_ff <= acc_b_in;
   end

   assign done   = done_ff;
   assign prod_a = acc_a_ff;
   assign prod_b = acc_b_ff;

endmodule
`default_nettype wire

/* sv/ffp_chk.sv */
// Frame-end checker: header rule checks and fragment count/length checks via ffp_mul.
// Depends on ffp_pkg, ffp_mul and fragment_frame_parser_defines.svh.
`default_nettype none
`include "fragment_frame_parser_defines.svh"
module ffp_chk (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic                   take,
   input  wire ffp_pkg::hdr_type       hdr,
   input  wire ffp_pkg::cfg_type       cfg,
   output ffp_pkg::chk_status_type     sts
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_MUL  = 5'b00010,
      ST_FIN1 = 5'b00100,
      ST_FIN2 = 5'b01000,
      ST_DONE = 5'b10000
   } chk_state_type;

   chk_state_type             state_ff, state_in;
   logic                      static_ok_ff, static_ok_in;
   logic                      ceil_ok_ff, ceil_ok_in;
   logic [15:0]               want_len_ff, want_len_in;
   logic                      bad_ff, bad_in;
   logic [ffp_pkg::POS_W-1:0] dlen;
   logic [15:0]               csize;
   logic                      mul_start;
   logic                      mul_done;
   logic [31:0]               prod_cnt;
   logic [31:0]               prod_idx;
   logic [31:0]               total_w;
   logic [31:0]               budget_w;

   assign dlen      = ffp_pkg::data_len_f(hdr.position);
   assign csize     = ffp_pkg::class_size_f(hdr.cls);
   assign total_w   = {16'd0, hdr.total};
   assign budget_w  = {16'd0, hdr.budget};
   assign mul_start = (state_ff == ST_IDLE) && start;

   ffp_mul u_mul (
      .clock    (clock),
      .reset    (reset),
      .start    (mul_start),
      .mcand    (hdr.budget),
      .mplier_a (hdr.count),
      .mplier_b (hdr.index),
      .done     (mul_done),
      .prod_a   (prod_cnt),
      .prod_b   (prod_idx)
   );

   always_comb begin
      state_in     = state_ff;
      static_ok_in = static_ok_ff;
      ceil_ok_in   = ceil_ok_ff;
      want_len_in  = want_len_ff;
      bad_in       = bad_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               static_ok_in = hdr.format_ok && (dlen != '0) &&
                              (dlen <= {1'b0, cfg.max_msg}) &&
                              (hdr.ident != '0) && (hdr.ident <= cfg.id_limit) &&
                              (hdr.total != '0) && (hdr.total <= cfg.max_msg) &&
                              (hdr.budget != '0) && (hdr.count != '0) &&
                              (hdr.cls < 8'(ffp_pkg::CLASS_LIMIT)) &&
                              (hdr.cls <= {4'd0, cfg.max_class}) &&
                              (hdr.total <= csize) && (hdr.index < hdr.count);
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            if (mul_done) state_in = ST_FIN1;
         end
         ST_FIN1: begin
            // check that count is the ceiling of total over budget
            ceil_ok_in = (prod_cnt >= total_w) && ((prod_cnt - budget_w) < total_w);
            if (({1'b0, hdr.index} + 17'd1) < {1'b0, hdr.count}) begin
               want_len_in = hdr.budget;
            end else begin
               want_len_in = hdr.total - prod_idx[15:0];
            end
            state_in = ST_FIN2;
         end
         ST_FIN2: begin
            bad_in   = !(static_ok_ff && ceil_ok_ff && (dlen == {1'b0, want_len_ff}));
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (take) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      static_ok_ff <= static_ok_in;
      ceil_ok_ff   <= ceil_ok_in;
      want_len_ff  <= want_len_in;
      bad_ff       <= bad_in;
   end

   assign sts.done      = (state_ff == ST_DONE);
   assign sts.malformed = bad_ff;

   `FFP_ASSERT_IMP(a_fin_follows_mul, clock, reset, state_ff == ST_FIN1, $past(mul_done))

endmodule
`default_nettype wire

/* dv/fragment_frame_parser_checker.sv */
`timescale 1ns / 100ps
// Checker for the fragment frame parser: mirrors the register writes, predicts the payload and
// summary results of every accepted request and compares them with the result channel.
// Depends on ffp_pkg.
module fragment_frame_parser_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  ffp_pkg::req_type               req_data,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  ffp_pkg::rsp_type               rsp_data,
   input  logic                           csr_write_en,
   input  logic [ffp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ffp_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                             fail_count,
   output int                             outstanding
);
   import ffp_pkg::*;

   int mismatches = 0;
   rsp_type frame_results_due[$];

   logic [7:0]       lim_type;
   logic [15:0]      lim_msg;
   logic [3:0]       lim_class;
   logic [63:0]      lim_ident;

   logic [POS_W-1:0] frame_pos;
   logic             hdr_ok;
   logic [7:0]       hdr_class;
   logic [63:0]      hdr_ident;
   logic [15:0]      hdr_total;
   logic [15:0]      hdr_index;
   logic [15:0]      hdr_count;
   logic [15:0]      hdr_budget;
   logic [31:0]      hdr_crc;

   assign fail_count = mismatches;

   task automatic restart_frame();
      frame_pos  = '0;
      hdr_ok     = 1'b1;
      hdr_class  = '0;
      hdr_ident  = '0;
      hdr_total  = '0;
      hdr_index  = '0;
      hdr_count  = '0;
      hdr_budget = '0;
      hdr_crc    = '0;
   endtask

   // Header consistency rules, applied once the payload length is known.
   function automatic bit fragment_fits(logic [POS_W-1:0] body_len);
      int unsigned total, budget, count, index, csize, want_count, want_len;
      total  = hdr_total;
      budget = hdr_budget;
      count  = hdr_count;
      index  = hdr_index;
      if (hdr_ident == 0 || hdr_ident > lim_ident || total == 0 || total > lim_msg ||
          budget == 0 || count == 0 || body_len == 0)
         return 1'b0;
      csize = (hdr_class < CLASS_LIMIT) ? (CLASS_BASE << hdr_class) : 0;
      if (csize == 0 || hdr_class > lim_class || total > csize)
         return 1'b0;
      want_count = (total + budget - 1) / budget;
      if (want_count == 0 || want_count > 65535 || count != want_count || index >= count)
         return 1'b0;
      want_len = (index + 1 < count) ? budget : total - index * budget;
      return body_len == want_len;
   endfunction

   task automatic absorb_frame_byte(logic [7:0] b, logic eof);
      rsp_type          r;
      logic [POS_W-1:0] body_len;
      if (frame_pos < OFS_END) begin
         if (frame_pos == OFS_TYPE) begin
            if (b != lim_type) hdr_ok = 1'b0;
         end else if (frame_pos == OFS_CLASS) begin
            hdr_class = b;
         end else if (frame_pos < OFS_IDENT) begin
            if (b != 8'd0) hdr_ok = 1'b0;
         end else if (frame_pos < OFS_TOTAL) begin
            hdr_ident = {hdr_ident[55:0], b};
         end else if (frame_pos < OFS_INDEX) begin
            hdr_total = {hdr_total[7:0], b};
         end else if (frame_pos < OFS_COUNT) begin
            hdr_index = {hdr_index[7:0], b};
         end else if (frame_pos < OFS_BUDGET) begin
            hdr_count = {hdr_count[7:0], b};
         end else if (frame_pos < OFS_CRC) begin
            hdr_budget = {hdr_budget[7:0], b};
         end else begin
            hdr_crc = {hdr_crc[23:0], b};
         end
      end else begin
         r = '0;
         r.payload_byte = b;
         frame_results_due.push_back(r);
      end
      if (frame_pos != POS_MAX) frame_pos = frame_pos + 1'b1;
      if (eof) begin
         body_len       = (frame_pos > OFS_END) ? frame_pos - OFS_END : '0;
         r              = '0;
         r.is_summary   = 1'b1;
         r.is_last      = 1'b1;
         r.status       = !(hdr_ok && frame_pos > OFS_END && body_len <= lim_msg &&
                            fragment_fits(body_len));
         r.msg_class    = hdr_class;
         r.msg_ident    = hdr_ident;
         r.total_len    = hdr_total;
         r.frag_index   = hdr_index;
         r.frag_count   = hdr_count;
         r.data_budget  = hdr_budget;
         r.msg_crc      = hdr_crc;
         r.payload_len  = (body_len > 17'hFFFF) ? 16'hFFFF : body_len[15:0];
         frame_results_due.push_back(r);
         restart_frame();
      end
   endtask

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         lim_type  = TYPE_CODE_RST;
         lim_msg   = MAX_MSG_RST;
         lim_class = MAX_CLASS_RST;
         lim_ident = ID_LIMIT_RST;
         restart_frame();
         frame_results_due.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (frame_results_due.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected result, expected none, actual 0x%0h", $time, rsp_data);
            end else begin
               want = frame_results_due.pop_front();
               check_field("is_summary", want.is_summary, rsp_data.is_summary);
               check_field("payload_byte", want.payload_byte, rsp_data.payload_byte);
               check_field("is_last", want.is_last, rsp_data.is_last);
               check_field("status", want.status, rsp_data.status);
               check_field("msg_class", want.msg_class, rsp_data.msg_class);
               check_field("msg_ident", want.msg_ident, rsp_data.msg_ident);
               check_field("total_len", want.total_len, rsp_data.total_len);
               check_field("frag_index", want.frag_index, rsp_data.frag_index);
               check_field("frag_count", want.frag_count, rsp_data.frag_count);
               check_field("data_budget", want.data_budget, rsp_data.data_budget);
               check_field("msg_crc", want.msg_crc, rsp_data.msg_crc);
               check_field("payload_len", want.payload_len, rsp_data.payload_len);
            end
         end
         if (req_valid && req_ready)
            absorb_frame_byte(req_data.in_byte, req_data.end_of_frame);
         if (csr_write_en) begin
            case (csr_index_type'(csr_index))
               CSR_TYPE_CODE: lim_type  = csr_wdata[7:0];
               CSR_MAX_MSG:   lim_msg   = csr_wdata[15:0];
               CSR_MAX_CLASS: lim_class = csr_wdata[3:0];
               CSR_ID_LIMIT:  lim_ident = csr_wdata;
               default: ;
            endcase
         end
      end
      outstanding <= frame_results_due.size();
   end

endmodule

/* dv/fragment_frame_parser_tb.sv */
`timescale 1ns / 100ps
// Top of the fragment frame parser testbench: clock, reset, frame stimulus and final verdict.
// Depends on ffp_pkg, fragment_frame_parser and fragment_frame_parser_checker.
module fragment_frame_parser_tb;
   import ffp_pkg::*;

   localparam int     HALF_PERIOD = 10;
   localparam longint CYCLE_LIMIT = 3000000;

   // Header as it goes on the wire, byte 0 in the top bits.
   typedef struct packed {
      logic [7:0]  type_code;
      logic [7:0]  cls;
      logic [15:0] pad;
      logic [63:0] ident;
      logic [15:0] total;
      logic [15:0] index;
      logic [15:0] count;
      logic [15:0] budget;
      logic [31:0] crc;
   } frag_hdr_t;

   logic                  clock        = 1'b0;
   logic                  reset        = 1'b1;
   logic                  req_valid    = 1'b0;
   logic                  req_ready;
   req_type               req_data     = '0;
   logic                  rsp_valid;
   logic                  rsp_ready    = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index    = '0;
   logic [CSR_DATA_W-1:0] csr_wdata    = '0;
   int                    fail_count;
   int                    outstanding;

   longint cycle_count = 0;
   bit     quiet       = 1'b0;   // when set, neither side idles
   int     stall_left  = 0;

   // Copy of the programmed limits, used to build well-formed frames.
   logic [7:0]  cur_type      = TYPE_CODE_RST;
   logic [15:0] cur_max_msg   = MAX_MSG_RST;
   logic [3:0]  cur_max_class = MAX_CLASS_RST;
   logic [63:0] cur_id_limit  = ID_LIMIT_RST;

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   fragment_frame_parser DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   fragment_frame_parser_checker frame_check (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .fail_count   (fail_count),
      .outstanding  (outstanding)
   );

   // Result side: mostly ready, with short stalls and now and then a long one.
   // Drive at the falling edge so the block sees a settled ready at the rising edge.
   always @(negedge clock) begin
      if (quiet) begin
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 99) < 75) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready  <= 1'b0;
         stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
                                                   : $urandom_range(0, 2);
      end
   end

   // Abort a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Idle cycles before a request: mostly none or a few, rarely a long gap.
   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Offer one byte and hold it until the block takes it.
   // Enter and leave at a falling edge; valid stays high when the next request follows at once.
   task automatic send_byte(logic [7:0] b, logic eof);
      int gap;
      gap = idle_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_data.in_byte  <= b;
      req_data.end_of_frame <= eof;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Send a frame of frame_len bytes: the header first (cut short if the frame is short),
   // then random payload. The last byte carries the end-of-frame mark.
   task automatic run_frame(frag_hdr_t h, int frame_len);
      logic [191:0] flat;
      logic [7:0]   b;
      flat = h;
      for (int i = 0; i < frame_len; i++) begin
         b = (i < HEADER_BYTES) ? flat[191 - 8 * i -: 8] : 8'($urandom_range(0, 255));
         send_byte(b, i == frame_len - 1);
      end
   endtask

   function automatic frag_hdr_t fragment_header(int unsigned cls, logic [63:0] ident,
                                                 int unsigned total, int unsigned index,
                                                 int unsigned count, int unsigned budget);
      return '{type_code: cur_type, cls: 8'(cls), pad: 16'h0, ident: ident,
               total: 16'(total), index: 16'(index), count: 16'(count),
               budget: 16'(budget), crc: $urandom};
   endfunction

   // Build a consistent fragment header under the current limits and return its payload size.
   // Keep budgets small so most frames stay short.
   task automatic make_good_header(output frag_hdr_t h, output int body);
      int unsigned c_hi, cls, tot_hi, total, budget, count, index;
      logic [63:0] ident;
      c_hi   = (cur_max_class > 8) ? 8 : cur_max_class;
      cls    = $urandom_range(0, c_hi);
      tot_hi = 32 << cls;
      if (tot_hi > cur_max_msg) tot_hi = cur_max_msg;
      if ($urandom_range(0, 3) == 0 || tot_hi <= 64) total = $urandom_range(1, tot_hi);
      else total = $urandom_range(1, 64);
      if (total <= 64 && $urandom_range(0, 4) == 0) budget = $urandom_range(total, 65535);
      else budget = $urandom_range(1, 24);
      count = (total + budget - 1) / budget;
      index = ($urandom_range(0, 2) == 0) ? count - 1 : $urandom_range(0, count - 1);
      body  = (index + 1 < count) ? budget : total - index * budget;
      ident = ($urandom_range(0, 7) == 0) ? cur_id_limit
                                          : ({$urandom, $urandom} % cur_id_limit) + 1;
      h = fragment_header(cls, ident, total, index, count, budget);
   endtask

   // One random frame: mostly well-formed, some with a single broken rule, some pure noise.
   task automatic random_frame(output int sent);
      frag_hdr_t   h;
      int          body, frame_len;
      int unsigned c_hi;
      quiet = ($urandom_range(0, 9) == 0);
      make_good_header(h, body);
      frame_len = HEADER_BYTES + body;
      c_hi = (cur_max_class > 8) ? 8 : cur_max_class;
      if ($urandom_range(0, 99) < 10) begin
         h = frag_hdr_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
         frame_len = $urandom_range(1, 60);
      end else if ($urandom_range(0, 99) < 40) begin
         case ($urandom_range(0, 11))
            0:  h.type_code = cur_type ^ 8'($urandom_range(1, 255));
            1:  h.pad = 16'($urandom_range(1, 65535));
            2:  h.ident = '0;
            3:  h.ident = (cur_id_limit != '1) ? cur_id_limit + 1 : '0;
            4:  h.total = '0;
            5:  h.total = cur_max_msg + 16'($urandom_range(1, 10));
            6:  h.cls = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(c_hi + 1, 15))
                                                    : 8'($urandom_range(c_hi + 1, 255));
            7:  h.budget = '0;
            8:  h.count = ($urandom_range(0, 1) == 0) ? h.count + 1'b1 : h.count - 1'b1;
            9:  h.index = h.count + 16'($urandom_range(0, 3));
            10: frame_len = ($urandom_range(0, 1) == 0) ? frame_len + 1 : frame_len - 1;
            default: frame_len = $urandom_range(1, HEADER_BYTES);
         endcase
      end
      run_frame(h, frame_len);
      sent = frame_len;
   endtask

   task automatic random_phase(int min_bytes, int min_frames);
      int bytes, frames, sent;
      bytes  = 0;
      frames = 0;
      while (bytes < min_bytes || frames < min_frames) begin
         random_frame(sent);
         bytes += sent;
         frames++;
      end
      quiet = 1'b0;
   endtask

   // Drop valid, wait for every predicted result, then let the summary logic settle.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      @(negedge clock);
   endtask

   // Program all four limits, one register per cycle, with junk above each narrower register's width.
   task automatic set_config(logic [7:0] tc, logic [15:0] mm, logic [3:0] mc, logic [63:0] il);
      logic [63:0] v;
      csr_write_en <= 1'b1;
      v = {$urandom, $urandom};
      v[7:0] = tc;
      csr_index <= CSR_TYPE_CODE;
      csr_wdata <= v;
      @(negedge clock);
      v = {$urandom, $urandom};
      v[15:0] = mm;
      csr_index <= CSR_MAX_MSG;
      csr_wdata <= v;
      @(negedge clock);
      v = {$urandom, $urandom};
      v[3:0] = mc;
      csr_index <= CSR_MAX_CLASS;
      csr_wdata <= v;
      @(negedge clock);
      csr_index <= CSR_ID_LIMIT;
      csr_wdata <= il;
      @(negedge clock);
      csr_write_en  <= 1'b0;
      cur_type      = tc;
      cur_max_msg   = mm;
      cur_max_class = mc;
      cur_id_limit  = il;
   endtask

   initial begin : stimulus
      frag_hdr_t h;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed frames under the reset limits.
      h = fragment_header(0, 64'd1, 1, 0, 1, 1);
      run_frame(h, 25);                                               // smallest valid fragment
      run_frame(fragment_header(8, '1, 8192, 81, 82, 101), 24 + 11);  // largest class, last part
      h = fragment_header(2, 64'h0123_4567_89AB_CDEF, 100, 1, 4, 30);
      run_frame(h, 54);                                               // middle fragment
      run_frame(h, 55);                                               // one payload byte too many
      run_frame(fragment_header(0, 64'd1, 1, 0, 1, 1), 1);            // lone end-of-frame byte
      run_frame(fragment_header(0, 64'd1, 1, 0, 1, 1), 24);           // header with no payload
      run_frame(fragment_header(9, 64'd1, 1, 0, 1, 1), 25);           // class without a size
      run_frame(fragment_header(0, 64'd1, 1, 0, 1, 0), 25);           // zero budget
      run_frame(fragment_header(0, 64'd0, 1, 0, 1, 1), 25);           // zero id
      run_frame(fragment_header(2, 64'd5, 100, 4, 4, 30), 54);        // index past the count
      run_frame(fragment_header(2, 64'd5, 100, 1, 3, 30), 54);        // wrong fragment count
      run_frame(fragment_header(0, 64'd7, 33, 0, 1, 33), 57);         // total beyond class size
      run_frame(frag_hdr_t'('1), 28);                                 // every header bit set
      run_frame(frag_hdr_t'('0), 25);                                 // every header bit clear

      random_phase(30, 1);
      wait_idle();

      set_config(8'hA5, 16'd200, 4'd3, 64'd1000);
      random_phase(30, 1);
      wait_idle();

      // Tightest limits: only a one-byte class 0 message with id 1 passes.
      set_config(8'h00, 16'd1, 4'd0, 64'd1);
      random_phase(30, 1);
      wait_idle();

      // Loosest limits: classes 9 to 15 pass the class limit but have no size.
      set_config(8'hFF, 16'hFFFF, 4'hF, '1);
      random_phase(30, 1);
      wait_idle();

      if (fail_count == 0 && outstanding == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

/* fragment_frame_parser.f */
+incdir+sv
sv/ffp_pkg.sv
sv/ffp_hdr.sv
sv/ffp_mul.sv
sv/ffp_chk.sv
sv/fragment_frame_parser.sv
dv/fragment_frame_parser_checker.sv
dv/fragment_frame_parser_tb.sv
